// File: rtl/core/aalg_pkg.sv
// Package for the antialiased line generator: sequencer and line phase
// types, request kinds, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package aalg_pkg;

   typedef enum logic [1:0] {
      SEQ_READY  = 2'd0,
      SEQ_DIVIDE = 2'd1,
      SEQ_SECOND = 2'd2
   } seq_state_type;

   typedef enum logic [2:0] {
      PHASE_IDLE    = 3'd0,
      PHASE_HORIZ   = 3'd1,
      PHASE_VERT    = 3'd2,
      PHASE_DIAG    = 3'd3,
      PHASE_STEEP   = 3'd4,
      PHASE_SHALLOW = 3'd5,
      PHASE_END     = 3'd6
   } line_phase_type;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic REG_CLIP_WIDTH  = 1'b0;
   localparam logic REG_CLIP_HEIGHT = 1'b1;

   localparam logic [8:0] CLIP_WIDTH_RESET  = 9'd240;
   localparam logic [8:0] CLIP_HEIGHT_RESET = 9'd160;

   localparam int COLOR_BITS = 8;

endpackage

// File: rtl/core/antialiased_line_generator.sv
// Top level of the antialiased line generator: line setup, step datapath,
// bit-serial slope divider and APB-style clip registers. Uses aalg_pkg.
`timescale 1ns / 1ps

// Start items and the steps of horizontal, vertical, diagonal or single-point lines
// give one beat; steps of steep or shallow lines give two beats through one output
// register, the second held until the output register is free and no new request
// taken before it is loaded. A steep or shallow start holds off new requests while
// the restoring divider retires one slope bit a cycle. Every beat is registered.
// Reset: synchronous, active high; clears line state, clip regs to 240 x 160.
module antialiased_line_generator #(
   parameter int COORD_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_start_x,
   input  logic [7:0]          req_start_y,
   input  logic [7:0]          req_end_x,
   input  logic [7:0]          req_end_y,
   input  logic [7:0]          req_base_color,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [9:0]   rsp_pixel_x,
   output logic signed [9:0]   rsp_pixel_y,
   output logic [7:0]          rsp_pixel_color,
   output logic                rsp_visible,
   output logic                rsp_last,
   output logic                rsp_line_done,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);
   localparam logic [7:0] COORD_MASK = 8'((64'd1 << COORD_BITS) - 64'd1);

   // ------------------------------------------------------------------
   // Clip registers
   // ------------------------------------------------------------------
   logic [8:0] clip_width_ff, clip_width_in;
   logic [8:0] clip_height_ff, clip_height_in;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      if (csr_write) begin
         if (paddr[2] == aalg_pkg::REG_CLIP_WIDTH) begin
            clip_width_in = pwdata[8:0];
         end else begin
            clip_height_in = pwdata[8:0];
         end
      end
   end

   always_comb begin
      case (paddr[2])
         aalg_pkg::REG_CLIP_WIDTH:  prdata = {23'd0, clip_width_ff};
         aalg_pkg::REG_CLIP_HEIGHT: prdata = {23'd0, clip_height_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   aalg_pkg::seq_state_type  seq_ff, seq_in;
   aalg_pkg::line_phase_type phase_ff, phase_in;

   logic [9:0]               cursor_x_ff, cursor_x_in;
   logic [9:0]               cursor_y_ff, cursor_y_in;
   logic [7:0]               target_x_ff, target_x_in;
   logic [7:0]               target_y_ff, target_y_in;
   logic                     x_neg_ff, x_neg_in;
   logic [FRACTION_BITS-1:0] error_acc_ff, error_acc_in;
   logic [FRACTION_BITS-1:0] slope_ff, slope_in;
   logic [7:0]               steps_ff, steps_in;
   logic [7:0]               line_color_ff, line_color_in;

   // divider
   logic [7:0]               rem_ff, rem_in;
   logic [7:0]               divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]      div_count_ff, div_count_in;

   // output register and held second beat
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [9:0]               rsp_x_ff, rsp_x_in;
   logic [9:0]               rsp_y_ff, rsp_y_in;
   logic [7:0]               rsp_color_ff, rsp_color_in;
   logic                     rsp_visible_ff, rsp_visible_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic [9:0]               held_x_ff, held_x_in;
   logic [9:0]               held_y_ff, held_y_in;
   logic [7:0]               held_color_ff, held_color_in;

   // sequencer controls
   logic accept;
   logic rsp_free;
   logic load_held;
   logic div_step;
   logic start_divides;
   logic step_two_beats;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         aalg_pkg::SEQ_READY: begin
            if (accept && start_divides) begin
               seq_in = aalg_pkg::SEQ_DIVIDE;
            end else if (accept && step_two_beats) begin
               seq_in = aalg_pkg::SEQ_SECOND;
            end
         end
         aalg_pkg::SEQ_DIVIDE: begin
            if (div_count_ff == CNT_BITS'(1)) begin
               seq_in = aalg_pkg::SEQ_READY;
            end
         end
         aalg_pkg::SEQ_SECOND: begin
            if (rsp_free) begin
               seq_in = aalg_pkg::SEQ_READY;
            end
         end
         default: seq_in = aalg_pkg::SEQ_READY;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      load_held = 1'b0;
      div_step  = 1'b0;
      case (seq_ff)
         aalg_pkg::SEQ_READY:  req_ready = rsp_free;
         aalg_pkg::SEQ_DIVIDE: div_step  = 1'b1;
         aalg_pkg::SEQ_SECOND: load_held = rsp_free;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   function automatic logic in_clip(input logic [9:0] x, input logic [9:0] y,
                                    input logic [8:0] cw, input logic [8:0] ch);
      in_clip = !x[9] && !y[9] && (x < {1'b0, cw}) && (y < {1'b0, ch});
   endfunction

   logic [7:0]               sx_m, sy_m, ex_m, ey_m;
   logic [7:0]               top_x, top_y, bot_x, bot_y;
   logic                     start_neg;
   logic [7:0]               adx, ady;
   logic [9:0]               dir_value;
   logic [FRACTION_BITS-1:0] acc_sum;
   logic                     carry;
   logic [7:0]               inten;
   logic [7:0]               steps_dec;
   logic [8:0]               rem_shift;
   logic                     q_bit;
   logic [9:0]               emit_x, emit_y;
   logic [7:0]               emit_color;
   logic                     emit_last, emit_done, emit_blank;

   always_comb begin
      sx_m = req_start_x & COORD_MASK;
      sy_m = req_start_y & COORD_MASK;
      ex_m = req_end_x & COORD_MASK;
      ey_m = req_end_y & COORD_MASK;
      // order endpoints top to bottom
      if (sy_m > ey_m) begin
         top_x = ex_m;
         top_y = ey_m;
         bot_x = sx_m;
         bot_y = sy_m;
      end else begin
         top_x = sx_m;
         top_y = sy_m;
         bot_x = ex_m;
         bot_y = ey_m;
      end
      start_neg = bot_x < top_x;
      adx       = start_neg ? (top_x - bot_x) : (bot_x - top_x);
      ady       = bot_y - top_y;

      dir_value = x_neg_ff ? 10'h3FF : 10'h001;
      acc_sum   = error_acc_ff + slope_ff;
      carry     = acc_sum <= error_acc_ff;
      inten     = acc_sum[FRACTION_BITS-1 -: 8];
      steps_dec = steps_ff - 8'd1;

      rem_shift = {rem_ff, 1'b0};
      q_bit     = rem_shift >= {1'b0, divisor_ff};

      start_divides  = (req_kind == aalg_pkg::KIND_START) && ady != 8'd0
                       && adx != 8'd0 && adx != ady;
      step_two_beats = (req_kind == aalg_pkg::KIND_STEP)
                       && (phase_ff == aalg_pkg::PHASE_STEEP
                           || phase_ff == aalg_pkg::PHASE_SHALLOW);

      // hold by default
      phase_in      = phase_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      x_neg_in      = x_neg_ff;
      error_acc_in  = error_acc_ff;
      slope_in      = slope_ff;
      steps_in      = steps_ff;
      line_color_in = line_color_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      div_count_in  = div_count_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_color_in = held_color_ff;

      emit_x     = cursor_x_ff;
      emit_y     = cursor_y_ff;
      emit_color = line_color_ff;
      emit_last  = 1'b1;
      emit_done  = 1'b0;
      emit_blank = 1'b0;

      if (accept && req_kind == aalg_pkg::KIND_START) begin
         cursor_x_in   = {2'b00, top_x};
         cursor_y_in   = {2'b00, top_y};
         target_x_in   = bot_x;
         target_y_in   = bot_y;
         x_neg_in      = start_neg;
         line_color_in = req_base_color;
         error_acc_in  = '0;
         slope_in      = '0;
         if (ady == 8'd0) begin
            phase_in = (adx == 8'd0) ? aalg_pkg::PHASE_IDLE : aalg_pkg::PHASE_HORIZ;
            steps_in = adx;
         end else if (adx == 8'd0) begin
            phase_in = aalg_pkg::PHASE_VERT;
            steps_in = ady;
         end else if (adx == ady) begin
            phase_in = aalg_pkg::PHASE_DIAG;
            steps_in = ady;
         end else if (ady > adx) begin
            phase_in   = aalg_pkg::PHASE_STEEP;
            steps_in   = ady - 8'd1;
            rem_in     = adx;
            divisor_in = ady;
         end else begin
            phase_in   = aalg_pkg::PHASE_SHALLOW;
            steps_in   = adx - 8'd1;
            rem_in     = ady;
            divisor_in = adx;
         end
         div_count_in = CNT_BITS'(FRACTION_BITS);
         emit_x       = {2'b00, top_x};
         emit_y       = {2'b00, top_y};
         emit_color   = req_base_color;
         emit_done    = (ady == 8'd0) && (adx == 8'd0);
      end else if (accept) begin
         case (phase_ff)
            aalg_pkg::PHASE_HORIZ, aalg_pkg::PHASE_VERT, aalg_pkg::PHASE_DIAG: begin
               if (phase_ff != aalg_pkg::PHASE_VERT) begin
                  cursor_x_in = cursor_x_ff + dir_value;
               end
               if (phase_ff != aalg_pkg::PHASE_HORIZ) begin
                  cursor_y_in = cursor_y_ff + 10'd1;
               end
               steps_in = steps_dec;
               if (steps_dec == 8'd0) begin
                  phase_in = aalg_pkg::PHASE_IDLE;
               end
               emit_x    = cursor_x_in;
               emit_y    = cursor_y_in;
               emit_done = steps_dec == 8'd0;
            end
            aalg_pkg::PHASE_STEEP, aalg_pkg::PHASE_SHALLOW: begin
               error_acc_in = acc_sum;
               if (phase_ff == aalg_pkg::PHASE_STEEP) begin
                  cursor_x_in = carry ? (cursor_x_ff + dir_value) : cursor_x_ff;
                  cursor_y_in = cursor_y_ff + 10'd1;
                  held_x_in   = cursor_x_in + dir_value;
                  held_y_in   = cursor_y_in;
               end else begin
                  cursor_y_in = carry ? (cursor_y_ff + 10'd1) : cursor_y_ff;
                  cursor_x_in = cursor_x_ff + dir_value;
                  held_x_in   = cursor_x_in;
                  held_y_in   = cursor_y_in + 10'd1;
               end
               held_color_in = line_color_ff + ~inten;
               if (steps_ff != 8'd0) begin
                  steps_in = steps_dec;
               end
               if (steps_in == 8'd0) begin
                  phase_in = aalg_pkg::PHASE_END;
               end
               emit_x     = cursor_x_in;
               emit_y     = cursor_y_in;
               emit_color = line_color_ff + inten;
               emit_last  = 1'b0;
            end
            aalg_pkg::PHASE_END: begin
               phase_in    = aalg_pkg::PHASE_IDLE;
               cursor_x_in = {2'b00, target_x_ff};
               cursor_y_in = {2'b00, target_y_ff};
               emit_x      = {2'b00, target_x_ff};
               emit_y      = {2'b00, target_y_ff};
               emit_done   = 1'b1;
            end
            default: begin
               // step with no active line: one blank beat
               phase_in   = aalg_pkg::PHASE_IDLE;
               emit_x     = '0;
               emit_y     = '0;
               emit_color = '0;
               emit_done  = 1'b1;
               emit_blank = 1'b1;
            end
         endcase
      end

      // restoring division, one quotient bit a cycle
      if (div_step) begin
         rem_in       = q_bit ? 8'(rem_shift - {1'b0, divisor_ff}) : rem_shift[7:0];
         slope_in     = {slope_ff[FRACTION_BITS-2:0], q_bit};
         div_count_in = div_count_ff - CNT_BITS'(1);
      end
   end

   // output register: load a fresh beat or the held second beat, drop on take
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_x_in       = emit_x;
         rsp_y_in       = emit_y;
         rsp_color_in   = emit_color;
         rsp_visible_in = !emit_blank
                          && in_clip(emit_x, emit_y, clip_width_ff, clip_height_ff);
         rsp_last_in    = emit_last;
         rsp_done_in    = emit_done;
      end else if (load_held) begin
         rsp_valid_in   = 1'b1;
         rsp_x_in       = held_x_ff;
         rsp_y_in       = held_y_ff;
         rsp_color_in   = held_color_ff;
         rsp_visible_in = in_clip(held_x_ff, held_y_ff, clip_width_ff, clip_height_ff);
         rsp_last_in    = 1'b1;
         rsp_done_in    = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= aalg_pkg::SEQ_READY;
         phase_ff       <= aalg_pkg::PHASE_IDLE;
         rsp_valid_ff   <= 1'b0;
         clip_width_ff  <= aalg_pkg::CLIP_WIDTH_RESET;
         clip_height_ff <= aalg_pkg::CLIP_HEIGHT_RESET;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         target_x_ff    <= '0;
         target_y_ff    <= '0;
         x_neg_ff       <= 1'b0;
         error_acc_ff   <= '0;
         slope_ff       <= '0;
         steps_ff       <= '0;
         line_color_ff  <= '0;
         div_count_ff   <= '0;
      end else begin
         seq_ff         <= seq_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         target_x_ff    <= target_x_in;
         target_y_ff    <= target_y_in;
         x_neg_ff       <= x_neg_in;
         error_acc_ff   <= error_acc_in;
         slope_ff       <= slope_in;
         steps_ff       <= steps_in;
         line_color_ff  <= line_color_in;
         div_count_ff   <= div_count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
      held_x_ff      <= held_x_in;
      held_y_ff      <= held_y_in;
      held_color_ff  <= held_color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = $signed(rsp_x_ff);
   assign rsp_pixel_y     = $signed(rsp_y_ff);
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_visible     = rsp_visible_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_line_done   = rsp_done_ff;

endmodule

// File: test/aalg_pixel_checker.sv
// Pixel beat checker for the antialiased line generator: follows the clip
// registers and the request beats, predicts each pixel beat and compares.
// Depends on aalg_pkg.
`timescale 1ns / 1ps

module aalg_pixel_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [7:0]        req_start_x,
   input  logic [7:0]        req_start_y,
   input  logic [7:0]        req_end_x,
   input  logic [7:0]        req_end_y,
   input  logic [7:0]        req_base_color,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic signed [9:0] rsp_pixel_x,
   input  logic signed [9:0] rsp_pixel_y,
   input  logic [7:0]        rsp_pixel_color,
   input  logic              rsp_visible,
   input  logic              rsp_last,
   input  logic              rsp_line_done,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic [31:0]       prdata,
   input  logic              pready,
   output int                pending_beats,
   output int                mismatch_count
);

   localparam int SLOPE_BITS = 16;

   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] color;
      logic       visible;
      logic       last;
      logic       done;
   } pixel_beat_type;

   pixel_beat_type pixel_queue[$];
   pixel_beat_type want;

   logic [8:0]     clip_w;
   logic [8:0]     clip_h;
   int             cur_x;
   int             cur_y;
   int             tgt_x;
   int             tgt_y;
   bit             x_back;      // line runs toward smaller columns
   logic [15:0]    err_acc;
   logic [15:0]    slope;
   logic [7:0]     steps_left;
   aalg_pkg::line_phase_type phase;
   logic [7:0]     line_col;

   task automatic report_mismatch(input string what);
      $display("%0t ns pixel check: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_pixel(input int x, input int y, input logic [7:0] color,
                              input bit last, input bit done, input bit may_show);
      pixel_beat_type b;
      b.x       = x[9:0];
      b.y       = y[9:0];
      b.color   = color;
      b.visible = may_show && x >= 0 && y >= 0 && x < int'(clip_w) && y < int'(clip_h);
      b.last    = last;
      b.done    = done;
      pixel_queue.push_back(b);
   endtask

   task automatic predict_start(input int sx, input int sy, input int ex, input int ey,
                                input logic [7:0] col);
      int t;
      int dx;
      int dy;
      // order endpoints top to bottom
      if (sy > ey) begin
         t = sx; sx = ex; ex = t;
         t = sy; sy = ey; ey = t;
      end
      dx = ex - sx;
      dy = ey - sy;
      x_back = dx < 0;
      if (dx < 0) dx = -dx;
      cur_x    = sx;
      cur_y    = sy;
      tgt_x    = ex;
      tgt_y    = ey;
      line_col = col;
      err_acc  = '0;
      slope    = '0;
      if (dy == 0) begin
         phase      = (dx == 0) ? aalg_pkg::PHASE_IDLE : aalg_pkg::PHASE_HORIZ;
         steps_left = 8'(dx);
      end else if (dx == 0) begin
         phase      = aalg_pkg::PHASE_VERT;
         steps_left = 8'(dy);
      end else if (dx == dy) begin
         phase      = aalg_pkg::PHASE_DIAG;
         steps_left = 8'(dy);
      end else if (dy > dx) begin
         phase      = aalg_pkg::PHASE_STEEP;
         slope      = 16'((dx << SLOPE_BITS) / dy);
         steps_left = 8'(dy - 1);
      end else begin
         phase      = aalg_pkg::PHASE_SHALLOW;
         slope      = 16'((dy << SLOPE_BITS) / dx);
         steps_left = 8'(dx - 1);
      end
      queue_pixel(sx, sy, col, 1'b1, phase == aalg_pkg::PHASE_IDLE, 1'b1);
   endtask

   task automatic predict_step();
      int          dir;
      logic [15:0] prev;
      logic [7:0]  shade;
      bit          carry;
      dir = x_back ? -1 : 1;
      case (phase)
         aalg_pkg::PHASE_HORIZ, aalg_pkg::PHASE_VERT, aalg_pkg::PHASE_DIAG: begin
            if (phase != aalg_pkg::PHASE_VERT) cur_x += dir;
            if (phase != aalg_pkg::PHASE_HORIZ) cur_y += 1;
            steps_left = steps_left - 8'd1;
            if (steps_left == 8'd0) phase = aalg_pkg::PHASE_IDLE;
            queue_pixel(cur_x, cur_y, line_col, 1'b1, phase == aalg_pkg::PHASE_IDLE, 1'b1);
         end
         aalg_pkg::PHASE_STEEP, aalg_pkg::PHASE_SHALLOW: begin
            prev    = err_acc;
            err_acc = err_acc + slope;
            carry   = err_acc <= prev;
            shade   = err_acc[SLOPE_BITS-1 -: 8];
            if (phase == aalg_pkg::PHASE_STEEP) begin
               if (carry) cur_x += dir;
               cur_y += 1;
               queue_pixel(cur_x, cur_y, line_col + shade, 1'b0, 1'b0, 1'b1);
               queue_pixel(cur_x + dir, cur_y, line_col + ~shade, 1'b1, 1'b0, 1'b1);
            end else begin
               if (carry) cur_y += 1;
               cur_x += dir;
               queue_pixel(cur_x, cur_y, line_col + shade, 1'b0, 1'b0, 1'b1);
               queue_pixel(cur_x, cur_y + 1, line_col + ~shade, 1'b1, 1'b0, 1'b1);
            end
            if (steps_left != 8'd0) steps_left = steps_left - 8'd1;
            if (steps_left == 8'd0) phase = aalg_pkg::PHASE_END;
         end
         aalg_pkg::PHASE_END: begin
            phase = aalg_pkg::PHASE_IDLE;
            cur_x = tgt_x;
            cur_y = tgt_y;
            queue_pixel(tgt_x, tgt_y, line_col, 1'b1, 1'b1, 1'b1);
         end
         default: begin
            // no line loaded: one dummy beat, never shown
            phase = aalg_pkg::PHASE_IDLE;
            queue_pixel(0, 0, 8'd0, 1'b1, 1'b1, 1'b0);
         end
      endcase
   endtask

   initial begin
      mismatch_count = 0;
      pending_beats  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         clip_w     = aalg_pkg::CLIP_WIDTH_RESET;
         clip_h     = aalg_pkg::CLIP_HEIGHT_RESET;
         cur_x      = 0;
         cur_y      = 0;
         tgt_x      = 0;
         tgt_y      = 0;
         x_back     = 1'b0;
         err_acc    = '0;
         slope      = '0;
         steps_left = '0;
         phase      = aalg_pkg::PHASE_IDLE;
         line_col   = '0;
         pixel_queue.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == aalg_pkg::REG_CLIP_WIDTH) clip_w = pwdata[8:0];
               else clip_h = pwdata[8:0];
            end else if (prdata != {23'd0, (paddr[2] == aalg_pkg::REG_CLIP_WIDTH) ?
                                            clip_w : clip_h})
            begin
               report_mismatch($sformatf("register read at %0d gave %0d", paddr, prdata));
            end
         end
         // compare first: a beat leaving now belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("pixel beat with nothing outstanding");
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_pixel_x != want.x)
                  report_mismatch($sformatf("pixel_x %0d, want %0d",
                                            rsp_pixel_x, $signed(want.x)));
               if (rsp_pixel_y != want.y)
                  report_mismatch($sformatf("pixel_y %0d, want %0d",
                                            rsp_pixel_y, $signed(want.y)));
               if (rsp_pixel_color != want.color)
                  report_mismatch($sformatf("pixel_color %0d, want %0d",
                                            rsp_pixel_color, want.color));
               if (rsp_visible != want.visible)
                  report_mismatch($sformatf("visible %0b, want %0b at (%0d,%0d)",
                                            rsp_visible, want.visible,
                                            $signed(want.x), $signed(want.y)));
               if (rsp_last != want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
               if (rsp_line_done != want.done)
                  report_mismatch($sformatf("line_done %0b, want %0b",
                                            rsp_line_done, want.done));
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == aalg_pkg::KIND_START)
               predict_start(int'(req_start_x), int'(req_start_y), int'(req_end_x),
                             int'(req_end_y), req_base_color);
            else
               predict_step();
         end
      end
      pending_beats = pixel_queue.size();
   end

endmodule

// File: test/tb_top.sv
// Top of the antialiased line generator testbench: clock, reset, request and
// clip register stimulus, response pacing and the verdict.
// Depends on aalg_pkg, antialiased_line_generator and aalg_pixel_checker.
`timescale 1ns / 1ps

module tb_top;

   // generous ceiling on the run length, well above what the whole test needs
   localparam int RUN_LIMIT       = 500000;
   // receiver hold-off long enough to back the block up into its request port
   localparam int LONG_HOLD       = 150;
   localparam logic [2:0] CLIP_WIDTH_ADDR  = {aalg_pkg::REG_CLIP_WIDTH, 2'b00};
   localparam logic [2:0] CLIP_HEIGHT_ADDR = {aalg_pkg::REG_CLIP_HEIGHT, 2'b00};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic [7:0]        req_start_x;
   logic [7:0]        req_start_y;
   logic [7:0]        req_end_x;
   logic [7:0]        req_end_y;
   logic [7:0]        req_base_color;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [9:0] rsp_pixel_x;
   logic signed [9:0] rsp_pixel_y;
   logic [7:0]        rsp_pixel_color;
   logic              rsp_visible;
   logic              rsp_last;
   logic              rsp_line_done;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int pending_beats;
   int mismatch_count;
   int cycle_count = 0;
   int items_sent  = 0;
   // 1-in-N odds that a gap or a stall burst starts; 0 turns idling off
   int gap_odds    = 4;
   int stall_odds  = 5;
   bit long_hold_go = 1'b0;

   antialiased_line_generator dut (.*);

   aalg_pixel_checker checker_inst (.*);

   // 10 ns clock, low half first
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("antialiased_line_generator verification failed");
         $finish;
      end
   end

   // Response pacing. Drive rsp_ready at every falling edge: random stall
   // bursts while stall_odds allows, plus one long hold-off on request,
   // counted here so the sender keeps offering beats meanwhile.
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && stall_odds != 0 &&
                      $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Drop valid and idle the request port; n sets how long.
   task automatic hold_off(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Offer one request beat and hold it until accepted. Called at a falling
   // edge; returns at a falling edge where nothing has been driven yet, so the
   // next beat can keep valid high without a glitch.
   task automatic offer_beat(input logic kind, input logic [7:0] sx, input logic [7:0] sy,
                             input logic [7:0] ex, input logic [7:0] ey,
                             input logic [7:0] col);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_base_color <= col;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
         hold_off($urandom_range(1, 9));
   endtask

   // Step beat; the endpoint and color fields are ignored, so fill them with noise.
   task automatic step_once();
      offer_beat(aalg_pkg::KIND_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
   endtask

   // Start a line and follow it with as many steps as it needs to finish
   // (the major-axis length), adjusted by extra: negative abandons the line
   // early, positive runs on into steps with no line loaded.
   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [7:0] col, input int extra);
      int run_x;
      int run_y;
      int steps;
      run_x = (ex > sx) ? ex - sx : sx - ex;
      run_y = (ey > sy) ? ey - sy : sy - ey;
      steps = ((run_x > run_y) ? run_x : run_y) + extra;
      offer_beat(aalg_pkg::KIND_START, 8'(sx), 8'(sy), 8'(ex), 8'(ey), col);
      if (steps > 0) repeat (steps) step_once();
   endtask

   // Move a coordinate by reach in a random direction, kept on the 0..255 grid.
   function automatic int aim(input int from, input int reach);
      int to;
      to = $urandom_range(0, 1) ? from + reach : from - reach;
      if (to < 0) to = from + reach;
      if (to > 255) to = from - reach;
      if (to < 0) to = 0;
      return to;
   endfunction

   // One random line: mostly short, now and then long, every case shape, and
   // mostly well-formed with some abandoned or overrun sequences.
   task automatic random_line();
      int sx;
      int sy;
      int ex;
      int ey;
      int reach;
      int pick;
      int extra;
      sx    = $urandom_range(0, 255);
      sy    = $urandom_range(0, 255);
      reach = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
      ex    = sx;
      ey    = sy;
      case ($urandom_range(0, 5))
         0: ex = aim(sx, reach);
         1: ey = aim(sy, reach);
         2: begin
            ex = aim(sx, reach);
            ey = aim(sy, reach);
         end
         3, 4: begin
            ex = aim(sx, $urandom_range(0, reach));
            ey = aim(sy, $urandom_range(0, reach));
         end
         default: ;   // single point
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 80) extra = 0;
      else if (pick < 90) extra = -int'($urandom_range(1, 12));
      else extra = $urandom_range(1, 3);
      draw_line(sx, sy, ex, ey, 8'($urandom_range(0, 255)), extra);
   endtask

   task automatic random_lines(input int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) random_line();
   endtask

   // Drop valid and wait until every predicted beat has come back, then long
   // enough for a slope division still running to finish before touching the
   // registers.
   task automatic drain();
      hold_off(1);
      while (pending_beats != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // One register access: setup cycle, access cycle, then release the bus.
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write both clip registers and read them back; the checker compares the reads.
   task automatic set_clip(input int w, input int h);
      csr_access(1'b1, CLIP_WIDTH_ADDR, 32'(w));
      csr_access(1'b1, CLIP_HEIGHT_ADDR, 32'(h));
      csr_access(1'b0, CLIP_WIDTH_ADDR, 32'd0);
      csr_access(1'b0, CLIP_HEIGHT_ADDR, 32'd0);
   endtask

   initial begin
      // every input known from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = aalg_pkg::KIND_START;
      req_start_x    = '0;
      req_start_y    = '0;
      req_end_x      = '0;
      req_end_y      = '0;
      req_base_color = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed lines at the reset clip of 240 x 160.
      step_once();                                  // step with no line loaded
      draw_line(255, 255, 255, 255, 8'h00, 1);      // single point, then an idle step
      draw_line(241, 159, 238, 159, 8'hFF, 0);      // leftward across the right clip edge
      draw_line(0, 162, 0, 158, 8'h80, 0);          // bottom-up vertical over the bottom edge
      draw_line(2, 0, 0, 2, 8'h01, 0);              // diagonal toward column 0
      draw_line(2, 0, 0, 3, 8'hC8, 1);              // steep leftward with carry, color wrap
      draw_line(0, 0, 200, 100, 8'h55, -197);       // long shallow line, abandoned
      draw_line(9, 9, 9, 9, 8'h3C, 0);              // restart over the abandoned line
      drain();

      // Full screen; the receiver backs off for a long stretch at the start
      // while the sender keeps pushing, so the block stalls its request port.
      set_clip(256, 256);
      long_hold_go = 1'b1;
      random_lines(200);
      drain();

      // Tiny and empty clip windows under heavy idling on both sides.
      gap_odds   = 2;
      stall_odds = 2;
      set_clip(1, 1);
      random_lines(100);
      drain();
      set_clip(0, 0);
      random_lines(60);
      drain();

      // Random windows, light idling.
      gap_odds   = 5;
      stall_odds = 8;
      repeat (2) begin
         set_clip($urandom_range(1, 256), $urandom_range(1, 256));
         random_lines(100);
         drain();
      end

      // Back to the reset window, no idling at all to the end.
      gap_odds   = 0;
      stall_odds = 0;
      set_clip(int'(aalg_pkg::CLIP_WIDTH_RESET), int'(aalg_pkg::CLIP_HEIGHT_RESET));
      random_lines(300);
      drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("antialiased_line_generator verification clean");
      end else begin
         $display("antialiased_line_generator verification failed");
      end
      $finish;
   end

endmodule
